// ===== rtl/hrhv_pkg.sv =====
// Shared types, codes and character tables for the HTTP request header validator.
package hrhv_pkg;

    // Default sizes
    localparam int HEADER_BUFFER_BYTES_DEF = 4096;
    localparam int HOST_MAX_CHARS_DEF      = 1025;

    // Verdict codes
    localparam logic [3:0] VERDICT_OK         = 4'd0;
    localparam logic [3:0] VERDICT_INCOMPLETE = 4'd1;
    localparam logic [3:0] VERDICT_TOO_LARGE  = 4'd2;
    localparam logic [3:0] VERDICT_BAD_TARGET = 4'd3;
    localparam logic [3:0] VERDICT_BAD_METHOD = 4'd4;
    localparam logic [3:0] VERDICT_BAD_PATH   = 4'd5;
    localparam logic [3:0] VERDICT_NO_VERSION = 4'd6;
    localparam logic [3:0] VERDICT_NO_HOST    = 4'd7;
    localparam logic [3:0] VERDICT_BAD_HOST   = 4'd8;

    // Response status codes
    localparam logic [8:0] STATUS_OK          = 9'd200;
    localparam logic [8:0] STATUS_BAD_REQUEST = 9'd400;
    localparam logic [8:0] STATUS_BAD_METHOD  = 9'd405;
    localparam logic [8:0] STATUS_TOO_LARGE   = 9'd413;

    // Control characters
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_TAB = 8'h09;

    // One received byte and its end-of-connection flag
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       connection_end;
    } hrhv_item_t;

    // One verdict
    typedef struct packed {
        logic [3:0]  verdict;
        logic [8:0]  http_status;
        logic [11:0] header_bytes;
    } hrhv_result_t;

    // Status code that goes with a verdict.
    function automatic logic [8:0] status_of(input logic [3:0] v);
        logic [8:0] s;
        case (v)
            VERDICT_OK:         s = STATUS_OK;
            VERDICT_TOO_LARGE:  s = STATUS_TOO_LARGE;
            VERDICT_BAD_METHOD: s = STATUS_BAD_METHOD;
            default:            s = STATUS_BAD_REQUEST;
        endcase
        return s;
    endfunction

    // Characters of "GET /".
    function automatic logic [7:0] get_char(input logic [2:0] i);
        logic [7:0] ch;
        case (i)
            3'd0:    ch = "G";
            3'd1:    ch = "E";
            3'd2:    ch = "T";
            3'd3:    ch = " ";
            default: ch = "/";
        endcase
        return ch;
    endfunction

    // Characters of "HTTP/1.1".
    function automatic logic [7:0] version_char(input logic [2:0] i);
        logic [7:0] ch;
        case (i)
            3'd0:    ch = "H";
            3'd1:    ch = "T";
            3'd2:    ch = "T";
            3'd3:    ch = "P";
            3'd4:    ch = "/";
            3'd5:    ch = "1";
            3'd6:    ch = ".";
            default: ch = "1";
        endcase
        return ch;
    endfunction

    // Characters of "\nhost:" in lower case.
    function automatic logic [7:0] key_char(input logic [2:0] i);
        logic [7:0] ch;
        case (i)
            3'd0:    ch = CHAR_LF;
            3'd1:    ch = "h";
            3'd2:    ch = "o";
            3'd3:    ch = "s";
            3'd4:    ch = "t";
            default: ch = ":";
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/hrhv_req_if.sv =====
// Request byte channel: valid, ready and one received byte with its end flag.
interface hrhv_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       connection_end;

    modport source (output valid, output rx_byte, output connection_end, input ready);
    modport sink   (input valid, input rx_byte, input connection_end, output ready);
endinterface

// ===== rtl/hrhv_res_if.sv =====
// Verdict channel: valid, ready and one verdict with status and byte count.
interface hrhv_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  verdict;
    logic [8:0]  http_status;
    logic [11:0] header_bytes;

    modport source (output valid, output verdict, output http_status, output header_bytes,
                    input ready);
    modport sink   (input valid, input verdict, input http_status, input header_bytes,
                    output ready);
endinterface

// ===== rtl/hrhv_in_reg.sv =====
// Input register: holds one accepted request until the matchers consume it.
module hrhv_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    hrhv_req_if.sink            req,
    input  logic                advance,
    output logic                item_valid,
    output hrhv_pkg::hrhv_item_t item
);

    logic                 valid_reg;
    logic                 valid_next;
    hrhv_pkg::hrhv_item_t item_reg;

    // Take a new request whenever the held one is empty or leaves this cycle.
    assign req.ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (req.ready)
        begin
            valid_next = req.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.rx_byte        <= req.rx_byte;
            item_reg.connection_end <= req.connection_end;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/hrhv_core.sv =====
// Matcher state and verdict logic: one request byte is processed per step.
module hrhv_core #(
    parameter int HEADER_BUFFER_BYTES = hrhv_pkg::HEADER_BUFFER_BYTES_DEF,
    parameter int HOST_MAX_CHARS      = hrhv_pkg::HOST_MAX_CHARS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  hrhv_pkg::hrhv_item_t   item,
    output logic                   emit,
    output hrhv_pkg::hrhv_result_t result
);

    localparam int CW = $clog2(HEADER_BUFFER_BYTES);
    localparam int LW = $clog2(HOST_MAX_CHARS + 1);
    localparam logic [CW-1:0] COUNT_LIMIT = CW'(HEADER_BUFFER_BYTES - 1);
    localparam logic [LW-1:0] HOST_LIMIT  = LW'(HOST_MAX_CHARS);

    // Host value phases
    localparam logic [2:0] HP_SEARCH  = 3'd0;
    localparam logic [2:0] HP_SKIP    = 3'd1;
    localparam logic [2:0] HP_PLAIN   = 3'd2;
    localparam logic [2:0] HP_BRACKET = 3'd3;
    localparam logic [2:0] HP_DONE    = 3'd4;
    localparam logic [2:0] HP_NONE    = 3'd5;

    // Method prefix states beyond the character positions
    localparam logic [2:0] PFX_SPACE   = 3'd4;
    localparam logic [2:0] PFX_SLASH   = 3'd5;
    localparam logic [2:0] PFX_NOSLASH = 3'd6;
    localparam logic [2:0] PFX_FAIL    = 3'd7;

    // Traversal matcher states
    localparam logic [2:0] TRV_IDLE  = 3'd0;
    localparam logic [2:0] TRV_SL    = 3'd1;
    localparam logic [2:0] TRV_SLDOT = 3'd2;
    localparam logic [2:0] TRV_PCT   = 3'd3;
    localparam logic [2:0] TRV_PCT2  = 3'd4;

    // Terminator matcher states
    localparam logic [1:0] TRM_IDLE   = 2'd0;
    localparam logic [1:0] TRM_CR     = 2'd1;
    localparam logic [1:0] TRM_CRLF   = 2'd2;
    localparam logic [1:0] TRM_CRLFCR = 2'd3;

    localparam logic [3:0] VER_LEN = 4'd8;
    localparam logic [2:0] KEY_LEN = 3'd6;

    logic [CW-1:0] byte_count_reg,  byte_count_next;
    logic          given_reg,       given_next;
    logic [1:0]    term_reg,        term_next;
    logic [2:0]    prefix_reg,      prefix_next;
    logic [2:0]    trav_reg,        trav_next;
    logic          trav_seen_reg,   trav_seen_next;
    logic [3:0]    ver_reg,         ver_next;
    logic          ver_seen_reg,    ver_seen_next;
    logic [2:0]    key_reg,         key_next;
    logic [2:0]    phase_reg,       phase_next;
    logic [LW-1:0] host_len_reg,    host_len_next;
    logic          host_bad_reg,    host_bad_next;

    logic [7:0]    c;
    logic [7:0]    lc;
    logic          take;
    logic          char_ok;
    logic          term_hit;
    logic [3:0]    verdict;
    logic [11:0]   count_out;

    assign c       = item.rx_byte;
    assign lc      = (c inside {["A":"Z"]}) ? c + 8'd32 : c;
    assign char_ok = c inside {["A":"Z"], ["a":"z"], ["0":"9"], "-", "."};

    always_comb
    begin
        byte_count_next = byte_count_reg;
        given_next      = given_reg;
        term_next       = term_reg;
        prefix_next     = prefix_reg;
        trav_next       = trav_reg;
        trav_seen_next  = trav_seen_reg;
        ver_next        = ver_reg;
        ver_seen_next   = ver_seen_reg;
        key_next        = key_reg;
        phase_next      = phase_reg;
        host_len_next   = host_len_reg;
        host_bad_next   = host_bad_reg;
        take            = 1'b0;
        term_hit        = 1'b0;
        emit            = 1'b0;
        verdict         = hrhv_pkg::VERDICT_OK;
        count_out       = 12'(byte_count_reg);

        if (step && item.connection_end)
        begin
            // Connection end: verdict if none yet, then rearm everything.
            emit            = !given_reg;
            verdict         = hrhv_pkg::VERDICT_INCOMPLETE;
            byte_count_next = '0;
            given_next      = 1'b0;
            term_next       = TRM_IDLE;
            prefix_next     = 3'd0;
            trav_next       = TRV_IDLE;
            trav_seen_next  = 1'b0;
            ver_next        = 4'd0;
            ver_seen_next   = 1'b0;
            key_next        = 3'd0;
            phase_next      = HP_SEARCH;
            host_len_next   = '0;
            host_bad_next   = 1'b0;
        end
        else if (step && !given_reg)
        begin
            byte_count_next = byte_count_reg + 1'b1;

            // Method and target prefix.
            if (prefix_reg < PFX_SPACE)
            begin
                prefix_next = (c == hrhv_pkg::get_char(prefix_reg)) ? prefix_reg + 3'd1
                                                                     : PFX_FAIL;
            end
            else if (prefix_reg == PFX_SPACE)
            begin
                prefix_next = (c == "/") ? PFX_SLASH : PFX_NOSLASH;
            end

            // Traversal: "/.." or "%2e".
            if (c == "." && trav_reg == TRV_SLDOT)
            begin
                trav_seen_next = 1'b1;
                trav_next      = TRV_IDLE;
            end
            else if (c == "e" && trav_reg == TRV_PCT2)
            begin
                trav_seen_next = 1'b1;
                trav_next      = TRV_IDLE;
            end
            else if (c == "/")
            begin
                trav_next = TRV_SL;
            end
            else if (c == "%")
            begin
                trav_next = TRV_PCT;
            end
            else if (c == "." && trav_reg == TRV_SL)
            begin
                trav_next = TRV_SLDOT;
            end
            else if (c == "2" && trav_reg == TRV_PCT)
            begin
                trav_next = TRV_PCT2;
            end
            else
            begin
                trav_next = TRV_IDLE;
            end

            // Version text anywhere.
            if (!ver_reg[3] && c == hrhv_pkg::version_char(ver_reg[2:0]))
            begin
                ver_next = ver_reg + 4'd1;
                if (ver_next == VER_LEN)
                begin
                    ver_seen_next = 1'b1;
                    ver_next      = 4'd0;
                end
            end
            else
            begin
                ver_next = (c == "H") ? 4'd1 : 4'd0;
            end

            // Host key and value.
            case (phase_reg)
                HP_SEARCH:
                begin
                    if (key_reg < KEY_LEN && lc == hrhv_pkg::key_char(key_reg))
                    begin
                        key_next = key_reg + 3'd1;
                        if (key_next == KEY_LEN)
                        begin
                            key_next   = 3'd0;
                            phase_next = HP_SKIP;
                        end
                    end
                    else
                    begin
                        key_next = (lc == hrhv_pkg::CHAR_LF) ? 3'd1 : 3'd0;
                    end
                end
                HP_SKIP:
                begin
                    if (c inside {" ", hrhv_pkg::CHAR_TAB})
                    begin
                        phase_next = HP_SKIP;
                    end
                    else if (c inside {hrhv_pkg::CHAR_CR, hrhv_pkg::CHAR_LF})
                    begin
                        phase_next = HP_NONE;
                    end
                    else if (c == "[")
                    begin
                        phase_next = HP_BRACKET;
                    end
                    else if (c == ":")
                    begin
                        host_bad_next = 1'b1;
                        phase_next    = HP_DONE;
                    end
                    else
                    begin
                        take       = 1'b1;
                        phase_next = HP_PLAIN;
                    end
                end
                HP_PLAIN:
                begin
                    if (c inside {":", " ", hrhv_pkg::CHAR_TAB, hrhv_pkg::CHAR_CR,
                                  hrhv_pkg::CHAR_LF})
                    begin
                        phase_next = HP_DONE;
                    end
                    else
                    begin
                        take = 1'b1;
                    end
                end
                HP_BRACKET:
                begin
                    if (c == "]")
                    begin
                        if (host_len_reg == '0)
                        begin
                            host_bad_next = 1'b1;
                        end
                        phase_next = HP_DONE;
                    end
                    else if (c inside {hrhv_pkg::CHAR_CR, hrhv_pkg::CHAR_LF})
                    begin
                        host_bad_next = 1'b1;
                        phase_next    = HP_DONE;
                    end
                    else
                    begin
                        take = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            // Only the first characters of the value are checked.
            if (take && host_len_reg < HOST_LIMIT)
            begin
                if (!char_ok)
                begin
                    host_bad_next = 1'b1;
                end
                host_len_next = host_len_reg + 1'b1;
            end

            // End of headers.
            if (c == hrhv_pkg::CHAR_CR)
            begin
                term_next = (term_reg == TRM_CRLF) ? TRM_CRLFCR : TRM_CR;
            end
            else if (c == hrhv_pkg::CHAR_LF && term_reg == TRM_CR)
            begin
                term_next = TRM_CRLF;
            end
            else if (c == hrhv_pkg::CHAR_LF && term_reg == TRM_CRLFCR)
            begin
                term_next = TRM_IDLE;
                term_hit  = 1'b1;
            end
            else
            begin
                term_next = TRM_IDLE;
            end

            count_out = 12'(byte_count_next);

            // Checks in order once the headers are complete.
            if (term_hit)
            begin
                given_next = 1'b1;
                emit       = 1'b1;
                if (prefix_next != PFX_SLASH)
                begin
                    verdict = (prefix_next == PFX_NOSLASH) ? hrhv_pkg::VERDICT_BAD_TARGET
                                                           : hrhv_pkg::VERDICT_BAD_METHOD;
                end
                else if (trav_seen_next)
                begin
                    verdict = hrhv_pkg::VERDICT_BAD_PATH;
                end
                else if (!ver_seen_next)
                begin
                    verdict = hrhv_pkg::VERDICT_NO_VERSION;
                end
                else if (phase_next inside {HP_SEARCH, HP_SKIP, HP_NONE})
                begin
                    verdict = hrhv_pkg::VERDICT_NO_HOST;
                end
                else if (phase_next == HP_BRACKET || host_bad_next)
                begin
                    verdict = hrhv_pkg::VERDICT_BAD_HOST;
                end
                else
                begin
                    verdict = hrhv_pkg::VERDICT_OK;
                end
            end
            else if (byte_count_next == COUNT_LIMIT)
            begin
                given_next = 1'b1;
                emit       = 1'b1;
                verdict    = hrhv_pkg::VERDICT_TOO_LARGE;
            end
        end
    end

    assign result.verdict      = verdict;
    assign result.http_status  = hrhv_pkg::status_of(verdict);
    assign result.header_bytes = count_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            given_reg      <= 1'b0;
            term_reg       <= TRM_IDLE;
            prefix_reg     <= 3'd0;
            trav_reg       <= TRV_IDLE;
            trav_seen_reg  <= 1'b0;
            ver_reg        <= 4'd0;
            ver_seen_reg   <= 1'b0;
            key_reg        <= 3'd0;
            phase_reg      <= HP_SEARCH;
            host_len_reg   <= '0;
            host_bad_reg   <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            given_reg      <= given_next;
            term_reg       <= term_next;
            prefix_reg     <= prefix_next;
            trav_reg       <= trav_next;
            trav_seen_reg  <= trav_seen_next;
            ver_reg        <= ver_next;
            ver_seen_reg   <= ver_seen_next;
            key_reg        <= key_next;
            phase_reg      <= phase_next;
            host_len_reg   <= host_len_next;
            host_bad_reg   <= host_bad_next;
        end
    end

    // Once a verdict is out, further bytes give nothing until connection end.
    assert property (@(posedge clk) disable iff (!rst_n)
        (given_reg && !item.connection_end) |-> !emit)
        else $error("verdict emitted twice for one request");

    // A connection end rearms the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.connection_end) |=> (byte_count_reg == '0 && !given_reg))
        else $error("block not rearmed after connection end");

    // The checked host length never passes its limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        host_len_reg <= HOST_LIMIT)
        else $error("host length beyond limit");

    // The byte count never passes the buffer limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= COUNT_LIMIT)
        else $error("byte count beyond buffer limit");

endmodule

// ===== rtl/hrhv_out_reg.sv =====
// Result register: holds one verdict until the receiver takes it.
module hrhv_out_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  hrhv_pkg::hrhv_result_t load_data,
    output logic                   can_take,
    hrhv_res_if.source             res
);

    logic                   valid_reg;
    logic                   valid_next;
    hrhv_pkg::hrhv_result_t data_reg;

    // Room for a new verdict when empty or when the held one leaves now.
    assign can_take = !valid_reg || res.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign res.valid        = valid_reg;
    assign res.verdict      = data_reg.verdict;
    assign res.http_status  = data_reg.http_status;
    assign res.header_bytes = data_reg.header_bytes;

endmodule

// ===== rtl/http_request_header_validator.sv =====
// Top level of the HTTP request header validator.
//
// The req channel carries one received byte per request (rx_byte) together
// with connection_end; the res channel carries one verdict per HTTP request
// with its status code (200, 400, 405 or 413) and the number of bytes counted.
// A verdict is given when CR LF CR LF ends the headers, when the byte limit
// of HEADER_BUFFER_BYTES - 1 is reached, or at connection end if none was
// given yet. Bytes after a verdict are dropped until connection end.
//
// Throughput is one request per cycle while res.ready is high: the matcher
// update is short logic between the input register and the result register,
// and a new request is accepted while the previous one is being matched. A
// verdict passes through the input register and then the result register
// before it is offered on res.
// When the receiver stalls, the verdict waits in the result register; the
// request in the input register waits behind it, so req.ready drops only
// while both are full and res.ready is low.
// Reset clears all matcher state and empties both registers.
module http_request_header_validator #(
    parameter int HEADER_BUFFER_BYTES = hrhv_pkg::HEADER_BUFFER_BYTES_DEF,
    parameter int HOST_MAX_CHARS      = hrhv_pkg::HOST_MAX_CHARS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    hrhv_req_if.sink   req,
    hrhv_res_if.source res
);

    logic                   item_valid;
    hrhv_pkg::hrhv_item_t   item;
    logic                   advance;
    logic                   can_take;
    logic                   emit;
    hrhv_pkg::hrhv_result_t result;

    // The held request is processed once the result register has room.
    assign advance = item_valid && can_take;

    hrhv_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    hrhv_core #(
        .HEADER_BUFFER_BYTES (HEADER_BUFFER_BYTES),
        .HOST_MAX_CHARS      (HOST_MAX_CHARS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item),
        .emit   (emit),
        .result (result)
    );

    hrhv_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && emit),
        .load_data (result),
        .can_take  (can_take),
        .res       (res)
    );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the HTTP request header validator: directed and random requests.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HDR_LIMIT     = 4096;
    localparam int HOST_LIMIT    = 1025;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_REPORTS   = 10;

    // Text the header matchers look for
    localparam logic [31:0] GET_TEXT      = "GET ";
    localparam logic [63:0] VERSION_TEXT  = "HTTP/1.1";
    localparam logic [47:0] HOST_KEY_TEXT = {hrhv_pkg::CHAR_LF, "host:"};
    localparam logic [31:0] HOST_WORD     = "host";

    // Character sets for random requests
    localparam string PATH_CHARS = "abcxyz019-_~/.%2eE";
    localparam string HOST_CHARS = {"abcdefghijklmnopqrstuvwxyz",
                                    "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-."};
    localparam string IPV6_CHARS = "0123456789abcdef:";

    // Request-line prefix tracker: 0 to 3 match "GET ", 4 awaits the slash
    localparam logic [2:0] PREFIX_SLASH_POS    = 3'd4;
    localparam logic [2:0] PREFIX_TARGET       = 3'd5;
    localparam logic [2:0] PREFIX_OTHER_TARGET = 3'd6;
    localparam logic [2:0] PREFIX_BAD_METHOD   = 3'd7;

    // Traversal tracker states
    localparam logic [2:0] TRAV_IDLE      = 3'd0;
    localparam logic [2:0] TRAV_SLASH     = 3'd1;
    localparam logic [2:0] TRAV_SLASH_DOT = 3'd2;
    localparam logic [2:0] TRAV_PERCENT   = 3'd3;
    localparam logic [2:0] TRAV_PERCENT_2 = 3'd4;

    // End-of-headers tracker states
    localparam logic [1:0] TERM_IDLE    = 2'd0;
    localparam logic [1:0] TERM_CR      = 2'd1;
    localparam logic [1:0] TERM_CRLF    = 2'd2;
    localparam logic [1:0] TERM_CRLF_CR = 2'd3;

    typedef enum logic [2:0] {
        HOST_SEARCH,
        HOST_SKIP,
        HOST_PLAIN,
        HOST_BRACKET,
        HOST_DONE,
        HOST_NONE
    } host_phase_e;

    logic clk;
    logic rst_n;

    hrhv_req_if req ();
    hrhv_res_if res ();

    http_request_header_validator #(
        .HEADER_BUFFER_BYTES(HDR_LIMIT),
        .HOST_MAX_CHARS     (HOST_LIMIT)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .res  (res)
    );

    // Predicted state of the request being parsed
    logic [11:0] byte_count;
    logic        verdict_given;
    logic [1:0]  term_progress;
    logic [2:0]  prefix_state;
    logic [2:0]  trav_progress;
    logic        trav_seen;
    logic [3:0]  version_progress;
    logic        version_seen;
    logic [2:0]  key_progress;
    host_phase_e host_phase;
    logic [10:0] host_length;
    logic        host_bad;

    hrhv_pkg::hrhv_result_t expected_verdicts[$];
    logic [7:0]             pending_bytes[$];

    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_off_cycles;
    int     mismatch_count;
    int     checked_verdicts;
    int     counted_bytes;
    longint cycle_count;

    function automatic bit chance(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // ------------------------------------------------------------------
    // Verdict predictor
    // ------------------------------------------------------------------

    function automatic void clear_request_state();
        byte_count       = '0;
        verdict_given    = 1'b0;
        term_progress    = TERM_IDLE;
        prefix_state     = '0;
        trav_progress    = TRAV_IDLE;
        trav_seen        = 1'b0;
        version_progress = '0;
        version_seen     = 1'b0;
        key_progress     = '0;
        host_phase       = HOST_SEARCH;
        host_length      = '0;
        host_bad         = 1'b0;
    endfunction

    function automatic bit host_char_legal(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               (c >= "0" && c <= "9") || c == "-" || c == ".";
    endfunction

    // Only the first HOST_LIMIT characters of the value are judged.
    function automatic void take_host_char(input logic [7:0] c);
        if (host_length < HOST_LIMIT)
        begin
            if (!host_char_legal(c))
                host_bad = 1'b1;
            host_length++;
        end
    endfunction

    function automatic void track_host(input logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        case (host_phase)
            HOST_SEARCH:
            begin
                if (key_progress < 6 && lc == HOST_KEY_TEXT[8*(5-key_progress) +: 8])
                begin
                    key_progress++;
                    if (key_progress == 3'd6)
                    begin
                        key_progress = '0;
                        host_phase   = HOST_SKIP;
                    end
                end
                else
                begin
                    key_progress = (lc == hrhv_pkg::CHAR_LF) ? 3'd1 : 3'd0;
                end
            end
            HOST_SKIP:
            begin
                if (c == hrhv_pkg::CHAR_CR || c == hrhv_pkg::CHAR_LF)
                begin
                    host_phase = HOST_NONE;
                end
                else if (c == "[")
                begin
                    host_phase = HOST_BRACKET;
                end
                else if (c == ":")
                begin
                    host_bad   = 1'b1;
                    host_phase = HOST_DONE;
                end
                else if (c != " " && c != hrhv_pkg::CHAR_TAB)
                begin
                    take_host_char(c);
                    host_phase = HOST_PLAIN;
                end
            end
            HOST_PLAIN:
            begin
                if (c == ":" || c == " " || c == hrhv_pkg::CHAR_TAB ||
                    c == hrhv_pkg::CHAR_CR || c == hrhv_pkg::CHAR_LF)
                    host_phase = HOST_DONE;
                else
                    take_host_char(c);
            end
            HOST_BRACKET:
            begin
                if (c == "]")
                begin
                    if (host_length == 0)
                        host_bad = 1'b1;
                    host_phase = HOST_DONE;
                end
                else if (c == hrhv_pkg::CHAR_CR || c == hrhv_pkg::CHAR_LF)
                begin
                    host_bad   = 1'b1;
                    host_phase = HOST_DONE;
                end
                else
                begin
                    take_host_char(c);
                end
            end
            default: ;
        endcase
    endfunction

    // Checks in order: method and target, traversal, version, host, host text.
    function automatic logic [3:0] header_verdict();
        if (prefix_state != PREFIX_TARGET)
            return (prefix_state == PREFIX_OTHER_TARGET) ? hrhv_pkg::VERDICT_BAD_TARGET
                                                          : hrhv_pkg::VERDICT_BAD_METHOD;
        if (trav_seen)
            return hrhv_pkg::VERDICT_BAD_PATH;
        if (!version_seen)
            return hrhv_pkg::VERDICT_NO_VERSION;
        if (host_phase == HOST_SEARCH || host_phase == HOST_SKIP || host_phase == HOST_NONE)
            return hrhv_pkg::VERDICT_NO_HOST;
        if (host_phase == HOST_BRACKET || host_bad)
            return hrhv_pkg::VERDICT_BAD_HOST;
        return hrhv_pkg::VERDICT_OK;
    endfunction

    function automatic void push_verdict(input logic [3:0] v);
        hrhv_pkg::hrhv_result_t r;
        r.verdict = v;
        case (v)
            hrhv_pkg::VERDICT_OK:         r.http_status = hrhv_pkg::STATUS_OK;
            hrhv_pkg::VERDICT_TOO_LARGE:  r.http_status = hrhv_pkg::STATUS_TOO_LARGE;
            hrhv_pkg::VERDICT_BAD_METHOD: r.http_status = hrhv_pkg::STATUS_BAD_METHOD;
            default:                      r.http_status = hrhv_pkg::STATUS_BAD_REQUEST;
        endcase
        r.header_bytes = byte_count;
        expected_verdicts.push_back(r);
    endfunction

    // Advances the predicted state by one request; returns 0 for an ignored byte.
    function automatic bit track_request_byte(input logic [7:0] c, input logic conn_end);
        bit headers_done;
        headers_done = 1'b0;
        if (conn_end)
        begin
            if (!verdict_given)
                push_verdict(hrhv_pkg::VERDICT_INCOMPLETE);
            clear_request_state();
            return 1'b1;
        end
        if (verdict_given)
            return 1'b0;

        byte_count++;

        // Method and target prefix
        if (prefix_state < PREFIX_SLASH_POS)
            prefix_state = (c == GET_TEXT[8*(3-prefix_state) +: 8]) ? prefix_state + 3'd1
                                                                    : PREFIX_BAD_METHOD;
        else if (prefix_state == PREFIX_SLASH_POS)
            prefix_state = (c == "/") ? PREFIX_TARGET : PREFIX_OTHER_TARGET;

        // Traversal patterns "/.." and "%2e"
        if (c == "." && trav_progress == TRAV_SLASH_DOT)
        begin
            trav_seen     = 1'b1;
            trav_progress = TRAV_IDLE;
        end
        else if (c == "e" && trav_progress == TRAV_PERCENT_2)
        begin
            trav_seen     = 1'b1;
            trav_progress = TRAV_IDLE;
        end
        else if (c == "/")
        begin
            trav_progress = TRAV_SLASH;
        end
        else if (c == "%")
        begin
            trav_progress = TRAV_PERCENT;
        end
        else if (c == "." && trav_progress == TRAV_SLASH)
        begin
            trav_progress = TRAV_SLASH_DOT;
        end
        else if (c == "2" && trav_progress == TRAV_PERCENT)
        begin
            trav_progress = TRAV_PERCENT_2;
        end
        else
        begin
            trav_progress = TRAV_IDLE;
        end

        // Version text anywhere in the headers
        if (version_progress < 8 && c == VERSION_TEXT[8*(7-version_progress) +: 8])
        begin
            version_progress++;
            if (version_progress == 4'd8)
            begin
                version_seen     = 1'b1;
                version_progress = '0;
            end
        end
        else
        begin
            version_progress = (c == "H") ? 4'd1 : 4'd0;
        end

        track_host(c);

        // End of headers
        if (c == hrhv_pkg::CHAR_CR)
        begin
            term_progress = (term_progress == TERM_CRLF) ? TERM_CRLF_CR : TERM_CR;
        end
        else if (c == hrhv_pkg::CHAR_LF && term_progress == TERM_CR)
        begin
            term_progress = TERM_CRLF;
        end
        else if (c == hrhv_pkg::CHAR_LF && term_progress == TERM_CRLF_CR)
        begin
            term_progress = TERM_IDLE;
            headers_done  = 1'b1;
        end
        else
        begin
            term_progress = TERM_IDLE;
        end

        if (headers_done)
        begin
            verdict_given = 1'b1;
            push_verdict(header_verdict());
        end
        else if (byte_count >= HDR_LIMIT - 1)
        begin
            verdict_given = 1'b1;
            push_verdict(hrhv_pkg::VERDICT_TOO_LARGE);
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Request text builders
    // ------------------------------------------------------------------

    function automatic void add_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            pending_bytes.push_back(s[i]);
    endfunction

    function automatic void add_line(input string s);
        add_text(s);
        add_byte(hrhv_pkg::CHAR_CR);
        add_byte(hrhv_pkg::CHAR_LF);
    endfunction

    function automatic void add_random_chars(input int count, input string alphabet);
        for (int i = 0; i < count; i++)
            pending_bytes.push_back(alphabet[$urandom_range(alphabet.len() - 1)]);
    endfunction

    // Arbitrary bytes with line breaks mixed in
    function automatic void add_random_bytes(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (chance(10))
                add_byte(chance(50) ? hrhv_pkg::CHAR_CR : hrhv_pkg::CHAR_LF);
            else
                add_byte(8'($urandom_range(255)));
        end
    endfunction

    function automatic void add_random_host();
        logic [7:0] ch;
        for (int i = 0; i < 4; i++)
        begin
            ch = HOST_WORD[8*(3-i) +: 8];
            add_byte(chance(50) ? ch - 8'd32 : ch);
        end
        add_text(":");
        repeat ($urandom_range(2))
            add_byte(chance(50) ? " " : hrhv_pkg::CHAR_TAB);
        case ($urandom_range(9))
            0: ;
            1:
            begin
                add_text("[");
                add_random_chars($urandom_range(5), IPV6_CHARS);
                if (chance(85))
                    add_text("]");
                if (chance(40))
                    add_text(":443");
            end
            2: add_text(":80");
            default:
            begin
                repeat ($urandom_range(1, 12))
                    add_byte(chance(90) ? HOST_CHARS[$urandom_range(HOST_CHARS.len() - 1)]
                                        : 8'($urandom_range(255)));
                if (chance(30))
                    add_text(":8080");
            end
        endcase
        add_line("");
    endfunction

    // A mostly well-formed request with random content and occasional defects
    function automatic void build_random_request();
        case ($urandom_range(19))
            0: add_text("POST ");
            1: add_text("GeT ");
            2: add_text("GET");
            3:
            begin
                add_line("");
                add_text("GET ");
            end
            default: add_text("GET ");
        endcase
        if (chance(90))
            add_text("/");
        add_random_chars($urandom_range(6), PATH_CHARS);
        if (chance(6))
            add_text("/..");
        if (chance(6))
            add_text("%2e");
        add_random_chars($urandom_range(4), PATH_CHARS);
        case ($urandom_range(9))
            0: add_text(" HTTP/1.0");
            1: add_text(" HTTP/1");
            default: add_text(" HTTP/1.1");
        endcase
        add_line("");
        if (chance(25))
            add_line("Accept: */*");
        if (chance(85))
            add_random_host();
        if (chance(20))
        begin
            add_text("X-Note: ");
            add_random_chars($urandom_range(1, 8), PATH_CHARS);
            add_line("");
        end
        if (chance(92))
            add_line("");
        if (chance(15))
            add_random_bytes($urandom_range(1, 6));
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------

    // Offers one request at the falling edge and waits for it to be taken.
    task automatic send_request(input logic [7:0] b, input logic conn_end);
        @(negedge clk);
        while (chance(send_idle_pct))
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid          <= 1'b1;
        req.rx_byte        <= b;
        req.connection_end <= conn_end;
        do
            @(posedge clk);
        while (req.ready !== 1'b1);
        if (track_request_byte(b, conn_end))
            counted_bytes++;
    endtask

    task automatic send_pending();
        logic [7:0] b;
        while (pending_bytes.size() != 0)
        begin
            b = pending_bytes.pop_front();
            send_request(b, 1'b0);
        end
    endtask

    // The byte that travels with the end flag is meaningless, so it is random.
    task automatic close_connection();
        send_request(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_simple_request(input string request_line, input string header_line);
        add_line(request_line);
        add_line(header_line);
        add_line("");
        send_pending();
        close_connection();
    endtask

    task automatic wait_for_verdicts();
        @(negedge clk);
        req.valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_connection_end();
        close_connection();
        close_connection();
        add_text("GET /");
        send_pending();
        close_connection();
        // Verdict from the headers, then a close that must stay silent
        add_line("");
        add_line("");
        send_pending();
        close_connection();
        wait_for_verdicts();
    endtask

    task automatic test_verdict_order();
        send_simple_request("GET / HTTP/1.1", "Host: example.com");
        send_simple_request("GET index.html HTTP/1.1", "Host: a");
        send_simple_request("POST / HTTP/1.1", "Host: a");
        send_simple_request("GET /a/../b HTTP/1.1", "Host: a");
        send_simple_request("GET /%2e%2e/x HTTP/1.1", "Host: a");
        send_simple_request("GET /%2E HTTP/1.1", "Host: a");
        send_simple_request("GET / HTTP/1.0", "Host: a");
        send_simple_request("GET / HTTP/1.1", "Accept: x");
        send_simple_request("POST /../ HTTP/1.0", "X: y");
        send_simple_request("GET /.. HTTP/1.0", "Host: a_b");
        wait_for_verdicts();
    endtask

    task automatic test_host_values();
        send_simple_request("GET / HTTP/1.1", "Host: [::1]");
        send_simple_request("GET / HTTP/1.1", "Host: [ab-1]:8080");
        send_simple_request("GET / HTTP/1.1", "Host: []");
        send_simple_request("GET / HTTP/1.1", "Host: [ab");
        send_simple_request("GET / HTTP/1.1", "Host: a_b");
        send_simple_request("GET / HTTP/1.1", "hOsT:\t host-1.example:80");
        send_simple_request("GET / HTTP/1.1", "Host:");
        send_simple_request("GET / HTTP/1.1", "Host: :80");
        send_simple_request("GET / HTTP/1.1", "X-Host: a");
        // Zero byte inside the host value, then one inside the target
        add_line("GET / HTTP/1.1");
        add_text("Host: a");
        add_byte(8'h00);
        add_line("b");
        add_line("");
        send_pending();
        close_connection();
        add_text("GET /");
        add_byte(8'h00);
        add_line(" HTTP/1.1");
        add_line("Host: a");
        add_line("");
        send_pending();
        close_connection();
        wait_for_verdicts();
    endtask

    task automatic test_after_verdict();
        add_line("GET / HTTP/1.1");
        add_line("Host: a");
        add_line("");
        add_line("GET /junk HTTP/1.1");
        add_byte(8'hFF);
        add_byte(8'h00);
        send_pending();
        send_request(8'hFF, 1'b1);
        wait_for_verdicts();
    endtask

    task automatic test_byte_limit();
        int filler;
        // No end of headers before the limit
        add_text("GET /");
        repeat (HDR_LIMIT - 1 - 5)
            add_byte("a");
        add_line("");
        add_line("");
        send_pending();
        close_connection();
        // End of headers lands exactly on the last byte allowed
        add_line("GET / HTTP/1.1");
        add_line("Host: a");
        add_text("X-Pad: ");
        filler = HDR_LIMIT - 1 - pending_bytes.size() - 4;
        repeat (filler)
            add_byte("p");
        add_line("");
        add_line("");
        send_pending();
        close_connection();
        wait_for_verdicts();
    endtask

    task automatic test_long_host();
        // Illegal character just past the checked length
        add_line("GET / HTTP/1.1");
        add_text("Host: ");
        repeat (HOST_LIMIT)
            add_byte("h");
        add_line("_");
        add_line("");
        send_pending();
        close_connection();
        // Illegal character as the last one checked
        add_line("GET / HTTP/1.1");
        add_text("Host: ");
        repeat (HOST_LIMIT - 1)
            add_byte("h");
        add_line("_");
        add_line("");
        send_pending();
        close_connection();
        // Bracketed value with a colon past the checked length
        add_line("GET / HTTP/1.1");
        add_text("Host: [");
        repeat (HOST_LIMIT)
            add_byte("h");
        add_line(":]");
        add_line("");
        send_pending();
        close_connection();
        wait_for_verdicts();
    endtask

    // Receiver holds off long enough for the block to fill and stall its input.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge clk);
        hold_off_cycles = 150;
        repeat (8)
        begin
            add_line("");
            add_line("");
            send_pending();
            close_connection();
        end
        send_simple_request("GET / HTTP/1.1", "Host: a");
        wait_for_verdicts();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int byte_budget);
        int bytes_start;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        bytes_start    = counted_bytes;
        while (counted_bytes - bytes_start < byte_budget)
        begin
            if (chance(10))
                add_random_bytes($urandom_range(1, 30));
            else
                build_random_request();
            send_pending();
            close_connection();
            if (chance(4))
                close_connection();
        end
        wait_for_verdicts();
    endtask

    // ------------------------------------------------------------------
    // Clock, receiver, checker and watchdog
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Verdict channel ready, with random stalls and an optional long hold-off
    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                res.ready <= 1'b0;
            end
            else
            begin
                res.ready <= !chance(recv_stall_pct);
            end
        end
    end

    // Compare each verdict taken with the oldest prediction.
    always @(posedge clk)
    begin : verdict_check
        hrhv_pkg::hrhv_result_t want;
        if (res.valid === 1'b1 && res.ready === 1'b1)
        begin
            checked_verdicts++;
            if (expected_verdicts.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("cycle %0d: unexpected verdict %0d status %0d bytes %0d",
                             cycle_count, res.verdict, res.http_status, res.header_bytes);
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (res.verdict !== want.verdict || res.http_status !== want.http_status ||
                    res.header_bytes !== want.header_bytes)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("cycle %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 cycle_count, want.verdict, want.http_status,
                                 want.header_bytes, res.verdict, res.http_status,
                                 res.header_bytes);
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("http_request_header_validator regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n              = 1'b0;
        req.valid          = 1'b0;
        req.rx_byte        = '0;
        req.connection_end = 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        hold_off_cycles    = 0;
        mismatch_count     = 0;
        checked_verdicts   = 0;
        counted_bytes      = 0;
        clear_request_state();

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_connection_end();
        test_verdict_order();
        test_host_values();
        test_after_verdict();
        test_byte_limit();
        test_long_host();
        test_backpressure();

        test_random_traffic(0, 0, 325);
        test_random_traffic(75, 0, 325);
        test_random_traffic(0, 75, 325);
        test_random_traffic(30, 30, 325);

        if (mismatch_count == 0 && expected_verdicts.size() == 0)
            $display("http_request_header_validator regression: pass");
        else
            $display("http_request_header_validator regression: fail");
        $finish;
    end

endmodule
